[hw/rtl/wait_slot_registration_table_macros.svh]
// Assertion macros shared by the wait slot registration table RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef WAIT_SLOT_REGISTRATION_TABLE_MACROS_SVH
`define WAIT_SLOT_REGISTRATION_TABLE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define WSRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define WSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define WSRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/wsrt_pkg.sv]
// Package of the wait slot registration table: sizes, opcodes, status codes
// and sequencer states. No dependencies.
package wsrt_pkg;

  // Table geometry.
  localparam int SLOT_COUNT  = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_AW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
  localparam int HALF_W      = 32;
  localparam int TOKEN_W     = 2 * HALF_W;

  // Field widths of the channels.
  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ARM    = 2'd0,
    OP_DISARM = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SCAN   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_INVALID = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_IGNORED = 3'd3,
    STAT_NONE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM,
    S_DIS,
    S_WALK,
    S_DONE
  } state_t;

endpackage

[hw/rtl/wsrt_in_if.sv]
// Input channel of the wait slot registration table: valid/ready plus one
// command item. Depends on wsrt_pkg.
interface wsrt_in_if
  import wsrt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [HALF_W-1:0]   notification;
  logic [HALF_W-1:0]   attempt;
  logic [INDEX_W-1:0]  slot_index;

  modport source (output valid, opcode, notification, attempt, slot_index, input ready);
  modport sink   (input valid, opcode, notification, attempt, slot_index, output ready);
endinterface

[hw/rtl/wsrt_out_if.sv]
// Result channel of the wait slot registration table: valid/ready plus one
// result item. Depends on wsrt_pkg.
interface wsrt_out_if
  import wsrt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  slot_number;
  logic [HALF_W-1:0]   token_notification;
  logic [HALF_W-1:0]   token_attempt;
  logic                last;

  modport source (output valid, status, slot_number, token_notification, token_attempt,
                  last, input ready);
  modport sink   (input valid, status, slot_number, token_notification, token_attempt,
                  last, output ready);
endinterface

[hw/rtl/wait_slot_registration_table.sv]
// Top level of the wait slot registration table: the sequencer and the token RAM.
// Depends on wsrt_pkg, wsrt_in_if, wsrt_out_if, wsrt_ram and wsrt_ctrl.
//
//   channel   direction  carries
//   in_ch     sink       opcode, notification, attempt, slot_index
//   out_ch    source     status, slot_number, token_notification, token_attempt, last
//
// Arm gives its result from S_ARM; disarm gives it from S_DIS after one RAM read,
// and a remove with a zero notification gives it from S_DONE without a read.
// Remove and scan walk the RAM one slot a cycle, a scan only while the sink takes each
// hit and stopping at its last token; a summary result (remove, or scan with none)
// comes from S_DONE. The single read port of the token RAM sets the walk rate.
// Reset clears the slot occupancy bits at once; the RAM itself is not cleared.
// A stalled result sink holds the scan walk at the current slot.
module wait_slot_registration_table
  import wsrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  wsrt_in_if.sink    in_ch,
  wsrt_out_if.source out_ch
);

  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [TOKEN_W-1:0] ram_wdata;
  logic               ram_re;
  logic [SLOT_AW-1:0] ram_raddr;
  logic [TOKEN_W-1:0] ram_rdata;

  // Sequencer, occupancy bits and result register.
  wsrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Token store, one 64-bit token per slot.
  wsrt_ram #(
    .WIDTH (TOKEN_W),
    .DEPTH (SLOT_COUNT)
  ) u_token_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hw/rtl/wsrt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module wsrt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/wsrt_ctrl.sv]
// Sequencer of the wait slot registration table: slot occupancy bits, walks
// over the token RAM and the result register. Depends on wsrt_pkg, the channel
// interfaces and the assertion macros.
`include "wait_slot_registration_table_macros.svh"

module wsrt_ctrl
  import wsrt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  wsrt_in_if.sink            in_ch,
  wsrt_out_if.source         out_ch,
  output logic               ram_we,
  output logic [SLOT_AW-1:0] ram_waddr,
  output logic [TOKEN_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [SLOT_AW-1:0] ram_raddr,
  input  logic [TOKEN_W-1:0] ram_rdata
);

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOT_COUNT - 1);

  state_t                state_r, state_nxt;
  op_t                   op_r;
  logic [HALF_W-1:0]     note_r;
  logic [HALF_W-1:0]     att_r;
  logic [INDEX_W-1:0]    idx_r;
  logic [SLOT_AW-1:0]    cnt_r;
  logic [RES_CW-1:0]     nres_r;
  logic [SLOT_COUNT-1:0] valid_r;
  status_t               done_status_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [INDEX_W-1:0]  out_slot_r;
  logic [HALF_W-1:0]   out_note_r;
  logic [HALF_W-1:0]   out_att_r;
  logic                out_last_r;

  logic                in_acc;
  logic                out_free;
  logic                emit;
  status_t             o_status;
  logic [INDEX_W-1:0]  o_slot;
  logic [HALF_W-1:0]   o_note;
  logic [HALF_W-1:0]   o_att;
  logic                o_last;
  logic                set_en;
  logic                clr_en;
  logic [SLOT_AW-1:0]  clr_idx;
  logic                advance;

  logic [SLOT_AW-1:0]    free_idx;
  logic                  table_full;
  logic [SLOT_COUNT-1:0] above;
  logic                  more_above;
  logic                  idx_ok;
  logic                  hit;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Lowest empty slot and the full flag, from the occupancy bits.
  always_comb begin
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SLOT_AW'(i);
      end
    end
  end
  assign table_full = &valid_r;

  // Whether any occupied slot lies above the one being walked.
  assign above      = valid_r >> cnt_r;
  assign more_above = |(above >> 1);

  // Disarm index check and the walk hit test for the slot just read.
  assign idx_ok = {1'b0, idx_r} < (INDEX_W + 1)'(SLOT_COUNT);
  assign hit    = valid_r[cnt_r] &&
                  ((op_r == OP_SCAN) || (ram_rdata[HALF_W-1:0] == note_r));

  // Outputs of the sequencer: RAM accesses, occupancy updates and results.
  always_comb begin
    in_ch.ready = 1'b0;
    emit        = 1'b0;
    o_status    = STAT_OK;
    o_slot      = '0;
    o_note      = '0;
    o_att       = '0;
    o_last      = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = free_idx;
    ram_wdata   = {att_r, note_r};
    ram_re      = 1'b0;
    ram_raddr   = '0;
    set_en      = 1'b0;
    clr_en      = 1'b0;
    clr_idx     = cnt_r;
    advance     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (op_t'(in_ch.opcode) == OP_DISARM) begin
            ram_re    = 1'b1;
            ram_raddr = in_ch.slot_index[SLOT_AW-1:0];
          end else if (op_t'(in_ch.opcode) == OP_SCAN ||
                       (op_t'(in_ch.opcode) == OP_REMOVE && in_ch.notification != '0)) begin
            ram_re    = 1'b1;
            ram_raddr = '0;
          end
        end
      end
      S_ARM: begin
        if (out_free) begin
          emit = 1'b1;
          if (note_r == '0 || att_r == '0) begin
            o_status = STAT_INVALID;
          end else if (table_full) begin
            o_status = STAT_FULL;
          end else begin
            o_slot = INDEX_W'(free_idx);
            o_note = note_r;
            o_att  = att_r;
            ram_we = 1'b1;
            set_en = 1'b1;
          end
        end
      end
      S_DIS: begin
        if (out_free) begin
          emit = 1'b1;
          if (idx_ok && valid_r[idx_r[SLOT_AW-1:0]] &&
              ram_rdata == {att_r, note_r}) begin
            o_slot  = idx_r;
            o_note  = note_r;
            o_att   = att_r;
            clr_en  = 1'b1;
            clr_idx = idx_r[SLOT_AW-1:0];
          end else begin
            o_status = STAT_IGNORED;
          end
        end
      end
      S_WALK: begin
        if (op_r == OP_REMOVE) begin
          advance = 1'b1;
          clr_en  = hit;
        end else begin
          advance = !hit || out_free;
          if (hit && out_free) begin
            emit   = 1'b1;
            o_slot = INDEX_W'(cnt_r);
            o_note = ram_rdata[HALF_W-1:0];
            o_att  = ram_rdata[TOKEN_W-1:HALF_W];
            o_last = !more_above || (nres_r + RES_CW'(1) == RES_CW'(MAX_RESULTS));
          end
        end
        if (advance && !(emit && o_last) && cnt_r != LAST_SLOT) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r + SLOT_AW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit     = 1'b1;
          o_status = done_status_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_ch.opcode))
            OP_ARM:    state_nxt = S_ARM;
            OP_DISARM: state_nxt = S_DIS;
            OP_REMOVE: state_nxt = (in_ch.notification == '0) ? S_DONE : S_WALK;
            OP_SCAN:   state_nxt = S_WALK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ARM, S_DIS, S_DONE: begin
        if (emit) begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (advance) begin
          if (emit && o_last) begin
            state_nxt = S_IDLE;
          end else if (cnt_r == LAST_SLOT) begin
            state_nxt = S_DONE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers: state, occupancy, walk position and result count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      cnt_r         <= '0;
      nres_r        <= '0;
      done_status_r <= STAT_OK;
    end else begin
      state_r <= state_nxt;
      if (set_en) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[clr_idx] <= 1'b0;
      end
      if (in_acc) begin
        cnt_r         <= '0;
        nres_r        <= '0;
        done_status_r <= STAT_INVALID;
      end else if (state_r == S_WALK && advance) begin
        cnt_r         <= cnt_r + SLOT_AW'(1);
        done_status_r <= (op_r == OP_REMOVE) ? STAT_OK : STAT_NONE;
        if (emit) begin
          nres_r <= nres_r + RES_CW'(1);
        end
      end
    end
  end

  // Command item captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= op_t'(in_ch.opcode);
      note_r <= in_ch.notification;
      att_r  <= in_ch.attempt;
      idx_r  <= in_ch.slot_index;
    end
  end

  // Result register: loaded on emit, emptied when the sink takes the item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= o_status;
      out_slot_r   <= o_slot;
      out_note_r   <= o_note;
      out_att_r    <= o_att;
      out_last_r   <= o_last;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.slot_number        = out_slot_r;
  assign out_ch.token_notification = out_note_r;
  assign out_ch.token_attempt      = out_att_r;
  assign out_ch.last               = out_last_r;

  // A held result is never overwritten by a new one.
  `WSRT_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_valid_r && !out_ch.ready, !emit, "result overwritten while held")
  // A successful arm marks the chosen slot occupied.
  `WSRT_ASSERT_NEXT(a_arm_sets_slot, clk, rst_n, set_en, valid_r[$past(free_idx)], "armed slot not marked occupied")
  // A stalled scan keeps its position in the walk.
  `WSRT_ASSERT_NEXT(a_walk_hold, clk, rst_n, state_r == S_WALK && !advance, $stable(cnt_r) && state_r == S_WALK, "walk moved while stalled")
  // The final result of an item returns the sequencer to idle.
  `WSRT_ASSERT_NEXT(a_last_to_idle, clk, rst_n, emit && o_last, state_r == S_IDLE, "sequencer busy after final result")

endmodule

[bench/tb_wait_slot_registration_table.sv]
// Self-checking testbench for the wait slot registration table: a scoreboard class
// predicts every result item, a plain task drives the command channel and an initial block the result ready.
// Depends on wsrt_pkg, wsrt_in_if, wsrt_out_if and the wait_slot_registration_table RTL.
module tb_wait_slot_registration_table;
  timeunit 1ns;
  timeprecision 1ps;
  import wsrt_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 50;
  localparam int RANDOM_ITEMS = 96;
  localparam int SEGMENTS     = 4;
  localparam int TAIL_CYCLES  = SLOT_COUNT + 8;
  localparam int POOL_SIZE    = 6;

  typedef struct packed {
    op_t                opcode;
    logic [HALF_W-1:0]  notification;
    logic [HALF_W-1:0]  attempt;
    logic [INDEX_W-1:0] slot_index;
  } command_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] slot_number;
    logic [HALF_W-1:0]  token_notification;
    logic [HALF_W-1:0]  token_attempt;
    logic               last;
  } result_t;

  // Shadow copy of the slot store plus the queue of results still owed by the block.
  class wait_table_scoreboard;
    logic [TOKEN_W-1:0] slots [SLOT_COUNT];
    result_t            owed [$];
    int unsigned        errors;
    int unsigned        commands;
    int unsigned        results;
    int unsigned        full_hits;
    int unsigned        disarm_hits;
    int unsigned        widest_scan;

    function new();
      foreach (slots[i]) slots[i] = '0;
      errors      = 0;
      commands    = 0;
      results     = 0;
      full_hits   = 0;
      disarm_hits = 0;
      widest_scan = 0;
    endfunction

    function void owe(status_t st, int slot, logic [TOKEN_W-1:0] tok, logic last);
      result_t r;
      r.status             = st;
      r.slot_number        = INDEX_W'(slot);
      r.token_notification = tok[HALF_W-1:0];
      r.token_attempt      = tok[TOKEN_W-1:HALF_W];
      r.last               = last;
      owed.push_back(r);
    endfunction

    // Apply one accepted command to the shadow store and queue what it must produce.
    function void note_command(command_t c);
      logic [TOKEN_W-1:0] tok;
      int                 free_slot;
      int                 hits [$];
      tok = {c.attempt, c.notification};
      commands++;
      case (c.opcode)
        OP_ARM: begin
          if (c.notification == '0 || c.attempt == '0) begin
            owe(STAT_INVALID, 0, '0, 1'b1);
          end else begin
            free_slot = -1;
            for (int s = 0; s < SLOT_COUNT; s++) begin
              if (free_slot < 0 && slots[s] == '0) free_slot = s;
            end
            if (free_slot < 0) begin
              full_hits++;
              owe(STAT_FULL, 0, '0, 1'b1);
            end else begin
              slots[free_slot] = tok;
              owe(STAT_OK, free_slot, tok, 1'b1);
            end
          end
        end
        OP_DISARM: begin
          if (c.slot_index < SLOT_COUNT && tok != '0 && slots[c.slot_index] == tok) begin
            slots[c.slot_index] = '0;
            disarm_hits++;
            owe(STAT_OK, c.slot_index, tok, 1'b1);
          end else begin
            owe(STAT_IGNORED, 0, '0, 1'b1);
          end
        end
        OP_REMOVE: begin
          if (c.notification == '0) begin
            owe(STAT_INVALID, 0, '0, 1'b1);
          end else begin
            foreach (slots[s]) begin
              if (slots[s][HALF_W-1:0] == c.notification) slots[s] = '0;
            end
            owe(STAT_OK, 0, '0, 1'b1);
          end
        end
        default: begin
          // Scan reports tokens with both halves set, lowest slots first, capped.
          foreach (slots[s]) begin
            if (hits.size() < MAX_RESULTS && slots[s][HALF_W-1:0] != '0 &&
                slots[s][TOKEN_W-1:HALF_W] != '0) hits.push_back(s);
          end
          if (hits.size() == 0) begin
            owe(STAT_NONE, 0, '0, 1'b1);
          end else begin
            foreach (hits[k]) owe(STAT_OK, hits[k], slots[hits[k]], k == hits.size() - 1);
          end
          if (hits.size() > widest_scan) widest_scan = hits.size();
        end
      endcase
    endfunction

    function void compare_field(string field, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: result %0d, %s expected 0x%0h, got 0x%0h", $time, results, field,
                 want, got);
      end
    endfunction

    // Compare one result item against the oldest owed one.
    function void check_result(result_t got);
      result_t want;
      results++;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: result %0d arrived with nothing owed, got status %0d slot %0d",
                 $time, results, got.status, got.slot_number);
        $display("  token 0x%h_%h last %0d", got.token_attempt, got.token_notification,
                 got.last);
        return;
      end
      want = owed.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("slot_number", want.slot_number, got.slot_number);
      compare_field("token_notification", want.token_notification, got.token_notification);
      compare_field("token_attempt", want.token_attempt, got.token_attempt);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  wsrt_in_if            in_ch ();
  wsrt_out_if           out_ch ();
  wait_table_scoreboard sb;
  int unsigned          items_issued;
  int unsigned          idle_cycles;
  int                   burst_left;
  bit                   held_off;
  logic [HALF_W-1:0]    note_pool [POOL_SIZE];

  wait_slot_registration_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Monitor both channels at the rising edge and keep the watchdog.
  always @(posedge clk) begin
    command_t c;
    result_t  r;
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready) begin
        c.opcode       = op_t'(in_ch.opcode);
        c.notification = in_ch.notification;
        c.attempt      = in_ch.attempt;
        c.slot_index   = in_ch.slot_index;
        sb.note_command(c);
      end
      if (out_ch.valid && out_ch.ready) begin
        r.status             = status_t'(out_ch.status);
        r.slot_number        = out_ch.slot_number;
        r.token_notification = out_ch.token_notification;
        r.token_attempt      = out_ch.token_attempt;
        r.last               = out_ch.last;
        sb.check_result(r);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Result receiver: stall patterns that change every so often, plus one long hold-off.
  initial begin
    int mode;
    int span;
    int period;
    int phase;
    out_ch.ready = 1'b0;
    phase = 0;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 120);
      period = $urandom_range(2, 5);
      repeat (span) begin
        @(negedge clk);
        if (!held_off && items_issued >= HOLD_AFTER) begin
          out_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          held_off = 1'b1;
        end
        phase++;
        case (mode)
          0:       out_ch.ready = 1'b1;
          1:       out_ch.ready = ($urandom_range(0, 1) == 0);
          2:       out_ch.ready = (phase % period == 0);
          default: out_ch.ready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  function automatic command_t make_cmd(op_t op, logic [HALF_W-1:0] note,
                                        logic [HALF_W-1:0] att, logic [INDEX_W-1:0] idx);
    command_t c;
    c.opcode       = op;
    c.notification = note;
    c.attempt      = att;
    c.slot_index   = idx;
    return c;
  endfunction

  // Offer one command from a falling edge and hold it until accepted; bursts and gaps.
  task automatic issue(command_t c);
    int gap;
    in_ch.opcode       = c.opcode;
    in_ch.notification = c.notification;
    in_ch.attempt      = c.attempt;
    in_ch.slot_index   = c.slot_index;
    in_ch.valid        = 1'b1;
    items_issued++;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Mostly well-formed commands drawn against the current shadow store, some noise.
  function automatic command_t random_command(int w_arm, int w_dis, int w_rem);
    command_t c;
    int       pick;
    int       live [$];
    int       s;
    c.opcode       = OP_SCAN;
    c.notification = $urandom;
    c.attempt      = $urandom;
    c.slot_index   = INDEX_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < w_arm) begin
      c.opcode = OP_ARM;
      if ($urandom_range(0, 1) == 0) c.notification = note_pool[$urandom_range(0, POOL_SIZE - 1)];
      case ($urandom_range(0, 19))
        0:       c.notification = '0;
        1:       c.attempt = '0;
        default: ;
      endcase
    end else if (pick < w_arm + w_dis) begin
      c.opcode = OP_DISARM;
      foreach (sb.slots[i]) begin
        if (sb.slots[i] != '0) live.push_back(i);
      end
      pick = $urandom_range(0, 9);
      if (live.size() > 0 && pick < 8) begin
        s = live[$urandom_range(0, live.size() - 1)];
        c.slot_index = INDEX_W'(s);
        {c.attempt, c.notification} = sb.slots[s];
        // A near miss: one bit of the token differs from the stored one.
        if (pick == 7) c.attempt = c.attempt ^ (32'h1 << $urandom_range(0, HALF_W - 1));
      end else if (pick == 9) begin
        c.slot_index = INDEX_W'($urandom_range(SLOT_COUNT, 63));
      end
    end else if (pick < w_arm + w_dis + w_rem) begin
      c.opcode = OP_REMOVE;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        c.notification = note_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (pick == 6) begin
        c.notification = '0;
      end
    end
    return c;
  endfunction

  // Main sequence: reset, directed commands, random segments, drain.
  initial begin
    int w_arm [SEGMENTS];
    int w_dis [SEGMENTS];
    int w_rem [SEGMENTS];
    w_arm              = '{75, 40, 20, 70};
    w_dis              = '{10, 25, 35, 10};
    w_rem              = '{5, 15, 30, 10};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = '0;
    in_ch.notification = '0;
    in_ch.attempt      = '0;
    in_ch.slot_index   = '0;
    items_issued       = 0;
    idle_cycles        = 0;
    burst_left         = 1;
    held_off           = 1'b0;
    sb = new();
    foreach (note_pool[i]) begin
      do note_pool[i] = $urandom; while (note_pool[i] == '0);
    end
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty scan, invalid arms, extreme tokens, every disarm outcome, removes.
    issue(make_cmd(OP_SCAN, '0, '0, '0));
    issue(make_cmd(OP_ARM, '0, 32'd5, '0));
    issue(make_cmd(OP_ARM, 32'd7, '0, '0));
    issue(make_cmd(OP_ARM, '0, '0, '0));
    issue(make_cmd(OP_ARM, '1, '1, '0));
    issue(make_cmd(OP_ARM, 32'd1, 32'd1, '0));
    issue(make_cmd(OP_ARM, 32'd1, 32'h8000_0000, '0));
    issue(make_cmd(OP_DISARM, '1, 32'hFFFF_FFFE, 6'd0));
    issue(make_cmd(OP_DISARM, '1, '1, 6'd16));
    issue(make_cmd(OP_DISARM, '1, '1, 6'd63));
    issue(make_cmd(OP_DISARM, '0, '0, 6'd0));
    issue(make_cmd(OP_DISARM, 32'd1, 32'd1, 6'd1));
    issue(make_cmd(OP_DISARM, 32'd1, 32'd1, 6'd1));
    issue(make_cmd(OP_ARM, 32'h8000_0000, 32'h1234_5678, '1));
    issue(make_cmd(OP_SCAN, '1, '1, '1));
    issue(make_cmd(OP_REMOVE, '0, '1, '0));
    issue(make_cmd(OP_REMOVE, 32'd1, '0, '0));
    issue(make_cmd(OP_REMOVE, 32'hDEAD_BEEF, '0, '0));
    issue(make_cmd(OP_DISARM, 32'h0BAD_F00D, 32'h0000_0042, 6'd15));
    issue(make_cmd(OP_SCAN, '0, '0, '0));
    issue(make_cmd(OP_REMOVE, '1, '0, '0));
    issue(make_cmd(OP_REMOVE, 32'h8000_0000, '0, '0));
    issue(make_cmd(OP_SCAN, '0, '0, '0));

    // Random segments: fill to full, mixed traffic, heavy clearing, refill.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      repeat (RANDOM_ITEMS / SEGMENTS) issue(random_command(w_arm[seg], w_dis[seg], w_rem[seg]));
      issue(make_cmd(OP_SCAN, $urandom, $urandom, INDEX_W'($urandom_range(0, 63))));
    end
    in_ch.valid = 1'b0;

    // Drain every owed result, then watch a little longer for strays.
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d results: %0d arms into a full table,",
             sb.commands, sb.results, sb.full_hits);
    $display("%0d successful disarms, widest scan %0d tokens, receiver held off %0d cycles.",
             sb.disarm_hits, sb.widest_scan, HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
